FILE: hdl/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg
// Shared widths, types and the arctangent table for the quaternion converter.
// ----------------------------------------------------------------------------
`default_nettype none

package qte_pkg;

	localparam int CORDIC_STAGES_DEF = 20;
	localparam int VW       = 40;
	localparam int ZW       = 35;
	localparam int AW       = 33;
	localparam int SQ_STEPS = 31;
	localparam int VSQ_W    = 62;
	localparam logic signed [29:0] DEG_K = 30'sd377515166;

	typedef struct packed {
		logic signed [31:0]   s;
		logic signed [VW-1:0] ry;
		logic signed [VW-1:0] rx;
		logic signed [VW-1:0] yy;
		logic signed [VW-1:0] yx;
	} qte_side_t;

	typedef struct packed {
		logic signed [VW-1:0] y;
		logic signed [VW-1:0] x;
	} qte_vec_t;

	function automatic logic [31:0] atan_tab(input int unsigned i);
		logic [31:0] r;
		case (i)
			0:       r = 32'h20000000;
			1:       r = 32'h12E4051E;
			2:       r = 32'h09FB385B;
			3:       r = 32'h051111D4;
			4:       r = 32'h028B0D43;
			5:       r = 32'h0145D7E1;
			6:       r = 32'h00A2F61E;
			7:       r = 32'h00517C55;
			8:       r = 32'h0028BE53;
			9:       r = 32'h00145F2F;
			10:      r = 32'h000A2F98;
			11:      r = 32'h000517CC;
			12:      r = 32'h00028BE6;
			13:      r = 32'h000145F3;
			14:      r = 32'h0000A2FA;
			15:      r = 32'h0000517D;
			16:      r = 32'h000028BE;
			17:      r = 32'h0000145F;
			18:      r = 32'h00000A30;
			19:      r = 32'h00000518;
			20:      r = 32'h0000028C;
			21:      r = 32'h00000146;
			22:      r = 32'h000000A3;
			23:      r = 32'h00000051;
			24:      r = 32'h00000029;
			25:      r = 32'h00000014;
			26:      r = 32'h0000000A;
			27:      r = 32'h00000005;
			28:      r = 32'h00000003;
			29:      r = 32'h00000001;
			30:      r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/quaternion_to_euler_angles.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// Z-Y-X Euler angles in Q16.16 degrees from a Q30 attitude quaternion.
// ----------------------------------------------------------------------------
// channel  dir  tdata fields (low bit up)                 width
// s_axis   in   quat_w, quat_x, quat_y, quat_z             128
// m_axis   out  pitch_deg, roll_deg, yaw_deg, zero pad     80
//
// The pipeline has three front stages, 31 square-root stages, the CORDIC
// fold, iterations and saturation, and two degree stages.
// Every stage is enabled by the output register; one beat enters per cycle
// unless a stalled output beat freezes the whole pipeline; nothing is dropped.
// Reset clears only the valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_to_euler_angles
	import qte_pkg::*;
#(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_axis_tvalid,
	output logic         s_axis_tready,
	input  wire [127:0]  s_axis_tdata,  // quat_w, quat_x, quat_y, quat_z
	output logic         m_axis_tvalid,
	input  wire          m_axis_tready,
	output logic [79:0]  m_axis_tdata   // pitch_deg, roll_deg, yaw_deg, pad
);

	logic               en;
	logic               f_valid, q_valid, c_valid, d_valid;
	logic [VSQ_W-1:0]   f_v;
	qte_side_t          f_side, q_side;
	logic [30:0]        q_root;
	qte_vec_t [2:0]     vin;
	logic [2:0][AW-1:0] ang;
	logic signed [23:0] pitch_deg;
	logic signed [24:0] roll_deg, yaw_deg;

	assign en            = !d_valid || m_axis_tready;
	assign s_axis_tready = en;

	qte_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_axis_tvalid),
		.w         (s_axis_tdata[31:0]),
		.x         (s_axis_tdata[63:32]),
		.y         (s_axis_tdata[95:64]),
		.z         (s_axis_tdata[127:96]),
		.out_valid (f_valid),
		.out_v     (f_v),
		.out_side  (f_side)
	);

	qte_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (f_valid),
		.in_v      (f_v),
		.in_side   (f_side),
		.out_valid (q_valid),
		.out_root  (q_root),
		.out_side  (q_side)
	);

	always_comb begin
		vin[0].y = VW'(q_side.s);
		vin[0].x = VW'({1'b0, q_root});
		vin[1].y = q_side.ry;
		vin[1].x = q_side.rx;
		vin[2].y = q_side.yy;
		vin[2].x = q_side.yx;
	end

	qte_cordic #(
		.CORDIC_STAGES (CORDIC_STAGES)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (q_valid),
		.vin       (vin),
		.out_valid (c_valid),
		.ang       (ang)
	);

	qte_deg u_deg (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (c_valid),
		.ang       (ang),
		.out_valid (d_valid),
		.pitch_deg (pitch_deg),
		.roll_deg  (roll_deg),
		.yaw_deg   (yaw_deg)
	);

	assign m_axis_tvalid = d_valid;
	assign m_axis_tdata  = {6'b000000, yaw_deg, roll_deg, pitch_deg};

	a_roll_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (roll_deg <= 25'sd11797349 && roll_deg >= -25'sd11797349))
		else $error("roll out of range");

	a_yaw_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (yaw_deg <= 25'sd11797349 && yaw_deg >= -25'sd11797349))
		else $error("yaw out of range");

	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("pipeline moved under stall");

endmodule

`default_nettype wire

FILE: hdl/qte_front.sv
// ----------------------------------------------------------------------------
// qte_front
// Products, sums with asin clamp, and the radicand 1 - s^2 (three stages).
// ----------------------------------------------------------------------------
`default_nettype none

module qte_front
	import qte_pkg::*;
(
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     en,
	input  wire                     in_valid,
	input  wire signed [31:0]       w,
	input  wire signed [31:0]       x,
	input  wire signed [31:0]       y,
	input  wire signed [31:0]       z,
	output logic                    out_valid,
	output logic [VSQ_W-1:0]        out_v,
	output qte_side_t               out_side
);

	logic signed [63:0] wy_s1, xz_s1, yz_s1, wx_s1, xx_s1;
	logic signed [63:0] yy_s1, xy_s1, wz_s1, ww_s1, zz_s1;
	logic               vld_s1, vld_s2, vld_s3;
	qte_side_t          side_s2, side_s3;
	logic [VSQ_W-1:0]   v_s3;

	logic signed [VW-1:0] qwy, qxz, qyz, qwx, qxx, qyy, qxy, qwz, qww, qzz;
	logic signed [VW-1:0] s_raw;
	qte_side_t            side_n;
	logic signed [63:0]   sq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wy_s1 <= w * y;
			xz_s1 <= x * z;
			yz_s1 <= y * z;
			wx_s1 <= w * x;
			xx_s1 <= x * x;
			yy_s1 <= y * y;
			xy_s1 <= x * y;
			wz_s1 <= w * z;
			ww_s1 <= w * w;
			zz_s1 <= z * z;
		end
	end

	always_comb begin
		qwy = VW'(wy_s1 >>> 30);
		qxz = VW'(xz_s1 >>> 30);
		qyz = VW'(yz_s1 >>> 30);
		qwx = VW'(wx_s1 >>> 30);
		qxx = VW'(xx_s1 >>> 30);
		qyy = VW'(yy_s1 >>> 30);
		qxy = VW'(xy_s1 >>> 30);
		qwz = VW'(wz_s1 >>> 30);
		qww = VW'(ww_s1 >>> 30);
		qzz = VW'(zz_s1 >>> 30);
		s_raw = (qwy - qxz) <<< 1;
		if (s_raw > 40'sd1073741824)
			side_n.s = 32'sd1073741824;
		else if (s_raw < -40'sd1073741824)
			side_n.s = -32'sd1073741824;
		else
			side_n.s = 32'(s_raw);
		side_n.ry = (qyz + qwx) <<< 1;
		side_n.rx = 40'sd1073741824 - ((qxx + qyy) <<< 1);
		side_n.yy = (qxy + qwz) <<< 1;
		side_n.yx = qww + qxx - qyy - qzz;
	end

	always_ff @(posedge clk) begin
		if (en)
			side_s2 <= side_n;
	end

	assign sq = side_s2.s * side_s2.s;

	always_ff @(posedge clk) begin
		if (en) begin
			v_s3    <= VSQ_W'(64'sh1000_0000_0000_0000 - sq);
			side_s3 <= side_s2;
		end
	end

	assign out_valid = vld_s3;
	assign out_v     = v_s3;
	assign out_side  = side_s3;

endmodule

`default_nettype wire

FILE: hdl/qte_sqrt.sv
// ----------------------------------------------------------------------------
// qte_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_sqrt
	import qte_pkg::*;
(
	input  wire               clk,
	input  wire               arst_n,
	input  wire               en,
	input  wire               in_valid,
	input  wire [VSQ_W-1:0]   in_v,
	input  qte_side_t         in_side,
	output logic              out_valid,
	output logic [30:0]       out_root,
	output qte_side_t         out_side
);

	logic [33:0]      rem_s  [SQ_STEPS];
	logic [30:0]      root_s [SQ_STEPS];
	logic [VSQ_W-1:0] vr_s   [SQ_STEPS];
	qte_side_t        side_s [SQ_STEPS];
	logic             vld_s  [SQ_STEPS];

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
		logic [33:0]      rem_c;
		logic [30:0]      root_c;
		logic [VSQ_W-1:0] vr_c;
		qte_side_t        side_c;
		logic             vld_c;
		logic [35:0]      trial, t;
		logic             ge;

		if (k == 0) begin : g_first
			assign rem_c  = '0;
			assign root_c = '0;
			assign vr_c   = in_v;
			assign side_c = in_side;
			assign vld_c  = in_valid;
		end else begin : g_rest
			assign rem_c  = rem_s[k-1];
			assign root_c = root_s[k-1];
			assign vr_c   = vr_s[k-1];
			assign side_c = side_s[k-1];
			assign vld_c  = vld_s[k-1];
		end

		assign trial = {rem_c, vr_c[VSQ_W-1 -: 2]};
		assign t     = {3'b000, root_c, 2'b01};
		assign ge    = (trial >= t);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k] <= 1'b0;
			else if (en)
				vld_s[k] <= vld_c;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? 34'(trial - t) : 34'(trial);
				root_s[k] <= {root_c[29:0], ge};
				vr_s[k]   <= {vr_c[VSQ_W-3:0], 2'b00};
				side_s[k] <= side_c;
			end
		end
	end

	assign out_valid = vld_s[SQ_STEPS-1];
	assign out_root  = root_s[SQ_STEPS-1];
	assign out_side  = side_s[SQ_STEPS-1];

endmodule

`default_nettype wire

FILE: hdl/qte_cordic.sv
// ----------------------------------------------------------------------------
// qte_cordic
// Three-lane vectoring CORDIC giving atan2 as a binary angle, one stage per
// iteration, with quadrant fold before and saturation after.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_cordic
	import qte_pkg::*;
#(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   en,
	input  wire                   in_valid,
	input  qte_vec_t [2:0]        vin,
	output logic                  out_valid,
	output logic [2:0][AW-1:0]    ang
);

	localparam logic signed [ZW-1:0] HALF = ZW'(64'sd2147483648);

	logic signed [VW-1:0] cx_s [CORDIC_STAGES+1][3];
	logic signed [VW-1:0] cy_s [CORDIC_STAGES+1][3];
	logic signed [ZW-1:0] cz_s [CORDIC_STAGES+1][3];
	logic                 zr_s [CORDIC_STAGES+1][3];
	logic                 vld_s [CORDIC_STAGES+2];
	logic [2:0][AW-1:0]   ang_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s[0] <= 1'b0;
		else if (en)
			vld_s[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				zr_s[0][l] <= (vin[l].x == '0) && (vin[l].y == '0);
				if (vin[l].x < 0) begin
					cx_s[0][l] <= -vin[l].x;
					cy_s[0][l] <= -vin[l].y;
					cz_s[0][l] <= (vin[l].y >= 0) ? HALF : -HALF;
				end else begin
					cx_s[0][l] <= vin[l].x;
					cy_s[0][l] <= vin[l].y;
					cz_s[0][l] <= '0;
				end
			end
		end
	end

	for (genvar j = 0; j < CORDIC_STAGES; j++) begin : g_iter
		localparam logic signed [ZW-1:0] ATAN = $signed({3'b000, atan_tab(j)});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[j+1] <= 1'b0;
			else if (en)
				vld_s[j+1] <= vld_s[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < 3; l++) begin
					zr_s[j+1][l] <= zr_s[j][l];
					if (cy_s[j][l] > 0) begin
						cx_s[j+1][l] <= cx_s[j][l] + (cy_s[j][l] >>> j);
						cy_s[j+1][l] <= cy_s[j][l] - (cx_s[j][l] >>> j);
						cz_s[j+1][l] <= cz_s[j][l] + ATAN;
					end else begin
						cx_s[j+1][l] <= cx_s[j][l] - (cy_s[j][l] >>> j);
						cy_s[j+1][l] <= cy_s[j][l] + (cx_s[j][l] >>> j);
						cz_s[j+1][l] <= cz_s[j][l] - ATAN;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s[CORDIC_STAGES+1] <= 1'b0;
		else if (en)
			vld_s[CORDIC_STAGES+1] <= vld_s[CORDIC_STAGES];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				if (zr_s[CORDIC_STAGES][l])
					ang_q[l] <= '0;
				else if (cz_s[CORDIC_STAGES][l] > HALF)
					ang_q[l] <= AW'(HALF);
				else if (cz_s[CORDIC_STAGES][l] < -HALF)
					ang_q[l] <= AW'(-HALF);
				else
					ang_q[l] <= AW'(cz_s[CORDIC_STAGES][l]);
			end
		end
	end

	assign out_valid = vld_s[CORDIC_STAGES+1];
	assign ang       = ang_q;

endmodule

`default_nettype wire

FILE: hdl/qte_deg.sv
// ----------------------------------------------------------------------------
// qte_deg
// Binary angle to Q16.16 degrees: split multiply, then sum and round.
// ----------------------------------------------------------------------------
`default_nettype none

module qte_deg
	import qte_pkg::*;
(
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  en,
	input  wire                  in_valid,
	input  wire [2:0][AW-1:0]    ang,
	output logic                 out_valid,
	output logic signed [23:0]   pitch_deg,
	output logic signed [24:0]   roll_deg,
	output logic signed [24:0]   yaw_deg
);

	logic signed [46:0] pa_s1 [3];
	logic signed [46:0] pb_s1 [3];
	logic signed [63:0] d_s2  [3];
	logic               vld_s1, vld_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				pa_s1[l] <= $signed(ang[l][AW-1:16]) * DEG_K;
				pb_s1[l] <= $signed({1'b0, ang[l][15:0]}) * DEG_K;
				d_s2[l]  <= ((64'(pa_s1[l]) <<< 16) + 64'(pb_s1[l])
					+ 64'sd34359738368) >>> 36;
			end
		end
	end

	assign out_valid = vld_s2;
	assign pitch_deg = d_s2[0][23:0];
	assign roll_deg  = d_s2[1][24:0];
	assign yaw_deg   = d_s2[2][24:0];

endmodule

`default_nettype wire

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for the quaternion to Euler angle converter. Feeds Q30
// quaternions, predicts pitch, roll and yaw from a bit-exact fixed-point
// model of the same CORDIC arithmetic and compares every output beat.
// ----------------------------------------------------------------------------
`default_nettype none

module tb
	import qte_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int  STAGES = CORDIC_STAGES_DEF;
	localparam int  N_RAND = 700;
	localparam int  N_DIR  = 18;
	localparam longint ONE = 64'sd1073741824;
	localparam longint HALF_TURN = 64'sd2147483648;
	localparam longint KDEG = 64'sd377515166;

	typedef struct packed {
		logic [24:0] yaw;
		logic [24:0] roll;
		logic [23:0] pitch;
	} angles_t;

	typedef struct {
		logic [31:0] w, x, y, z;
		logic        known;
		angles_t     ang;
	} dir_row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata = '0;  // quat_w, quat_x, quat_y, quat_z
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [79:0]  m_axis_tdata;       // pitch_deg, roll_deg, yaw_deg, pad

	angles_t   angles_q[$];
	int        errors = 0;
	int        n_in = 0;
	int        n_out = 0;
	int        send_idle = 0;
	int        recv_stall = 0;
	dir_row_t  dir_rows[N_DIR];

	quaternion_to_euler_angles DUT (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#50ms;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint qmul(longint a, longint b);
		return floor_shift(a * b, 30);
	endfunction

	function automatic longint isqrt(longint v);
		longint r, b;
		r = 0;
		b = 64'sd1 <<< 62;
		while (b > v)
			b = b >>> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >>> 1) + b;
			end else begin
				r = r >>> 1;
			end
			b = b >>> 2;
		end
		return r;
	endfunction

	function automatic longint cordic_angle(longint y, longint x);
		longint a, nx, ny, t;
		a = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			a = (y >= 0) ? HALF_TURN : -HALF_TURN;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < STAGES && i < 32; i++) begin
			t = longint'(atan_tab(i));
			if (y > 0) begin
				nx = x + floor_shift(y, i);
				ny = y - floor_shift(x, i);
				a = a + t;
			end else begin
				nx = x - floor_shift(y, i);
				ny = y + floor_shift(x, i);
				a = a - t;
			end
			x = nx;
			y = ny;
		end
		if (a > HALF_TURN)
			a = HALF_TURN;
		if (a < -HALF_TURN)
			a = -HALF_TURN;
		return a;
	endfunction

	function automatic longint degrees(longint a);
		return floor_shift(a * KDEG + (64'sd1 <<< 35), 36);
	endfunction

	function automatic angles_t euler_angles(logic [31:0] qw, logic [31:0] qx,
	                                         logic [31:0] qy, logic [31:0] qz);
		longint w, x, y, z, s, c, ry, rx, yy, yx;
		longint p, r, yw;
		angles_t o;
		w = longint'($signed(qw));
		x = longint'($signed(qx));
		y = longint'($signed(qy));
		z = longint'($signed(qz));
		s = 2 * (qmul(w, y) - qmul(x, z));
		if (s > ONE)
			s = ONE;
		if (s < -ONE)
			s = -ONE;
		c = isqrt((64'sd1 <<< 60) - s * s);
		ry = 2 * (qmul(y, z) + qmul(w, x));
		rx = ONE - 2 * (qmul(x, x) + qmul(y, y));
		yy = 2 * (qmul(x, y) + qmul(w, z));
		yx = qmul(w, w) + qmul(x, x) - qmul(y, y) - qmul(z, z);
		p = degrees(cordic_angle(s, c));
		r = degrees(cordic_angle(ry, rx));
		yw = degrees(cordic_angle(yy, yx));
		o.pitch = p[23:0];
		o.roll = r[24:0];
		o.yaw = yw[24:0];
		return o;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch at beat %0d: %s got %0h want %0h", n_out, what, got, want);
		errors++;
	endtask

	task automatic send(logic [31:0] w, x, y, z);
		while (send_idle > 0 && $urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {z, y, x, w};
		angles_q.push_back(euler_angles(w, x, y, z));
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		n_in++;
	endtask

	function automatic logic [31:0] rand_comp(int mode);
		case (mode)
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 2 * 1073741824) - 1073741824));
			default: return 32'($signed($urandom_range(0, 2048)) - 1024);
		endcase
	endfunction

	// receiver: stall at random, check each beat against the oldest prediction
	always @(posedge clk) begin
		angles_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = angles_t'(m_axis_tdata[73:0]);
			if (angles_q.size() == 0) begin
				$display("unexpected output beat %0d", n_out);
				errors++;
			end else begin
				want = angles_q.pop_front();
				if (got.pitch !== want.pitch)
					report("pitch_deg", 32'(got.pitch), 32'(want.pitch));
				if (got.roll !== want.roll)
					report("roll_deg", 32'(got.roll), 32'(want.roll));
				if (got.yaw !== want.yaw)
					report("yaw_deg", 32'(got.yaw), 32'(want.yaw));
				if (m_axis_tdata[79:74] !== '0)
					report("pad", 32'(m_axis_tdata[79:74]), 0);
			end
			n_out++;
		end
		m_axis_tready <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);
	end

	initial begin
		int ph, wait_cnt;
		logic [31:0] w, x, y, z;
		dir_rows = '{
			'{32'h4000_0000, 0, 0, 0, 1'b0, '0},
			'{0, 0, 0, 0, 1'b0, '0},
			'{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0, '0},
			'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, '0},
			'{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b0, '0},
			'{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b0, '0},
			'{0, 32'h4000_0000, 0, 0, 1'b0, '0},
			'{0, 0, 32'h4000_0000, 0, 1'b0, '0},
			'{0, 0, 0, 32'h4000_0000, 1'b0, '0},
			'{32'h2d41_3ccd, 0, 32'h2d41_3ccd, 0, 1'b0, '0},
			'{32'h2d41_3ccd, 0, 32'hd2be_c333, 0, 1'b0, '0},
			'{32'h2000_0000, 32'h2000_0000, 32'h2000_0000, 32'h2000_0000, 1'b0, '0},
			'{32'h4000_0000, 0, 32'h4000_0000, 0, 1'b0, '0},
			'{32'h4000_0000, 0, 32'hc000_0000, 0, 1'b0, '0},
			'{0, 32'hc000_0000, 0, 32'h0000_0001, 1'b0, '0},
			'{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b0, '0},
			'{32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 1'b0, '0},
			'{32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 1'b0, '0}
		};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			send(dir_rows[i].w, dir_rows[i].x, dir_rows[i].y, dir_rows[i].z);
			if (dir_rows[i].known)
				angles_q[angles_q.size() - 1] = dir_rows[i].ang;
		end

		for (int i = 0; i < N_RAND; i++) begin
			ph = i / (N_RAND / 4);
			send_idle  = (ph == 1) ? 49 : (ph == 3) ? 26 : 0;
			recv_stall = (ph == 2) ? 49 : (ph == 3) ? 26 : 0;
			if (i % 50 < 10) begin
				send_idle = 0;
				recv_stall = 0;
			end
			w = rand_comp($urandom_range(2));
			x = rand_comp($urandom_range(2));
			y = rand_comp($urandom_range(2));
			z = rand_comp($urandom_range(2));
			send(w, x, y, z);
		end
		s_axis_tvalid <= 1'b0;
		recv_stall = 0;

		wait_cnt = 0;
		while (angles_q.size() != 0 && wait_cnt < 20000) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (STAGES + 60) @(posedge clk);

		$display("sent %0d quaternions (directed extremes and random), checked %0d beats",
		         n_in, n_out);
		$display("idle and stall phases covered: none, sender, receiver, both");
		if (errors == 0 && angles_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d errors, %0d beats missing", errors, angles_q.size());
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
